FILE: sv/gzc_pkg.sv
// ----------------------------------------------------------------------------
// gzc_pkg
// shared types, constants and rounding helpers of the geofence zone classifier
// ----------------------------------------------------------------------------
package gzc_pkg;

   localparam int MAX_EDGES_DEF = 64;

   localparam logic [31:0] Y_SCALE       = 32'd47757857;
   localparam logic [31:0] X_SCALE_RESET = 32'd47757888;
   localparam logic [30:0] COORD_MAX     = 31'h3FFF_FFFF;
   localparam logic [23:0] DIST_MAX      = 24'hFF_FFFF;

   localparam logic [2:0] ZONE_GREEN      = 3'd0;
   localparam logic [2:0] ZONE_LIGHT_BLUE = 3'd1;
   localparam logic [2:0] ZONE_BLUE       = 3'd2;
   localparam logic [2:0] ZONE_DARK_BLUE  = 3'd3;
   localparam logic [2:0] ZONE_YELLOW     = 3'd4;
   localparam logic [2:0] ZONE_RED        = 3'd5;
   localparam logic [2:0] ZONE_BLACK      = 3'd6;

   localparam logic [2:0] REG_CENTER_LAT  = 3'd0;
   localparam logic [2:0] REG_CENTER_LON  = 3'd1;
   localparam logic [2:0] REG_X_SCALE     = 3'd2;
   localparam logic [2:0] REG_LIGHT_BLUE  = 3'd3;
   localparam logic [2:0] REG_BLUE        = 3'd4;
   localparam logic [2:0] REG_DARK_BLUE   = 3'd5;
   localparam logic [2:0] REG_YELLOW      = 3'd6;
   localparam logic [2:0] REG_RED         = 3'd7;

   typedef logic signed [31:0] coord_type;
   typedef logic signed [33:0] wide_type;

   typedef struct packed {
      logic signed [30:0] center_lat;
      logic signed [31:0] center_lon;
      logic [31:0]        x_scale;
      logic [4:0][23:0]   limit;
   } cfg_type;

   typedef struct packed {
      logic               req_type;
      logic               edge_final;
      logic [5:0]         edge_index;
      logic signed [30:0] start_lat;
      logic signed [31:0] start_lon;
      logic signed [30:0] end_lat;
      logic signed [31:0] end_lon;
      logic signed [30:0] point_lat;
      logic signed [31:0] point_lon;
   } req_fields_type;

   typedef struct packed {
      logic signed [30:0] start_lat;
      logic signed [31:0] start_lon;
      logic signed [30:0] end_lat;
      logic signed [31:0] end_lon;
   } edge_type;

   // round half away from zero at bit 24, saturate, apply sign
   function automatic coord_type proj_fin(input logic [67:0] p, input logic neg);
      logic [67:0] r;
      logic [30:0] m;
      r = (p + 68'h80_0000) >> 24;
      m = (r > {37'd0, COORD_MAX}) ? COORD_MAX : r[30:0];
      return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   // round half away from zero at bit 32, apply sign
   function automatic wide_type tscale_fin(input logic [67:0] p, input logic neg);
      logic [67:0] r;
      r = (p + 68'h8000_0000) >> 32;
      return neg ? -$signed({1'b0, r[32:0]}) : $signed({1'b0, r[32:0]});
   endfunction

endpackage

FILE: sv/geofence_zone_classifier.sv
// ----------------------------------------------------------------------------
// geofence_zone_classifier
// point in fence test with minimum edge distance and zone mapping
//
//   port group  dir  role
//   clock/reset in   single clock, synchronous active-high reset
//   req_*       in   edge load or position query request
//   rsp_*       out  zone and signed distance, one per query
//   csr_*       in   register access, centre, x scale and zone limits
//
// a load request is taken while idle; a query walks the edges one by one,
// with a 32 step divider only when the projection falls inside the edge
// and a 32 step square root for every edge; products share one 34x34 multiplier.
// req_tready is low while a query runs; a finished query holds in its done
// state while the previous response still waits.
// reset clears edge count and control; edge table contents stay undefined.
// ----------------------------------------------------------------------------
module geofence_zone_classifier
   import gzc_pkg::*;
#(
   parameter int MAX_EDGES = MAX_EDGES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [199:0] req_tdata,  // edge_index, start_lat, start_lon, end_lat,
                                    // end_lon, point_lat, point_lon, zero pad
   input  logic         req_tlast,  // edge_final
   input  logic         req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,  // zone, signed_distance, zero pad
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type        cfg_ff, cfg_in;
   req_fields_type req;
   logic           csr_we;
   logic [2:0]     reg_sel;
   logic [2:0]     zone;
   logic [24:0]    dist_out;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_sel)
            REG_CENTER_LAT: cfg_in.center_lat = csr_pwdata[30:0];
            REG_CENTER_LON: cfg_in.center_lon = csr_pwdata;
            REG_X_SCALE:    cfg_in.x_scale    = csr_pwdata;
            REG_LIGHT_BLUE: cfg_in.limit[0]   = csr_pwdata[23:0];
            REG_BLUE:       cfg_in.limit[1]   = csr_pwdata[23:0];
            REG_DARK_BLUE:  cfg_in.limit[2]   = csr_pwdata[23:0];
            REG_YELLOW:     cfg_in.limit[3]   = csr_pwdata[23:0];
            REG_RED:        cfg_in.limit[4]   = csr_pwdata[23:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CENTER_LAT: csr_prdata = {cfg_ff.center_lat[30], cfg_ff.center_lat};
         REG_CENTER_LON: csr_prdata = cfg_ff.center_lon;
         REG_X_SCALE:    csr_prdata = cfg_ff.x_scale;
         REG_LIGHT_BLUE: csr_prdata = {8'd0, cfg_ff.limit[0]};
         REG_BLUE:       csr_prdata = {8'd0, cfg_ff.limit[1]};
         REG_DARK_BLUE:  csr_prdata = {8'd0, cfg_ff.limit[2]};
         REG_YELLOW:     csr_prdata = {8'd0, cfg_ff.limit[3]};
         REG_RED:        csr_prdata = {8'd0, cfg_ff.limit[4]};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_lat <= '0;
         cfg_ff.center_lon <= '0;
         cfg_ff.x_scale    <= X_SCALE_RESET;
         cfg_ff.limit      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req.req_type   = req_tuser;
   assign req.edge_final = req_tlast;
   assign req.edge_index = req_tdata[5:0];
   assign req.start_lat  = req_tdata[36:6];
   assign req.start_lon  = req_tdata[68:37];
   assign req.end_lat    = req_tdata[99:69];
   assign req.end_lon    = req_tdata[131:100];
   assign req.point_lat  = req_tdata[162:132];
   assign req.point_lon  = req_tdata[194:163];

   gzc_core #(
      .MAX_EDGES (MAX_EDGES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res_zone  (zone),
      .res_dist  (dist_out)
   );

   assign rsp_tdata = {4'd0, dist_out, zone};

endmodule

FILE: sv/gzc_core.sv
// ----------------------------------------------------------------------------
// gzc_core
// edge table, sequencer and shared multiplier; divide and square root steps
// ----------------------------------------------------------------------------
module gzc_core
   import gzc_pkg::*;
#(
   parameter int MAX_EDGES = MAX_EDGES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_fields_type req,
   output logic           res_valid,
   input  logic           res_ready,
   output logic [2:0]     res_zone,
   output logic [24:0]    res_dist
);

   localparam int AW = $clog2(MAX_EDGES);
   localparam int CW = $clog2(MAX_EDGES + 1);

   localparam logic [5:0] S_IDLE = 6'd0;
   localparam logic [5:0] S_P1   = 6'd1;
   localparam logic [5:0] S_P2   = 6'd2;
   localparam logic [5:0] S_P3   = 6'd3;
   localparam logic [5:0] S_P4   = 6'd4;
   localparam logic [5:0] S_E0   = 6'd5;
   localparam logic [5:0] S_E1   = 6'd6;
   localparam logic [5:0] S_E2   = 6'd7;
   localparam logic [5:0] S_E3   = 6'd8;
   localparam logic [5:0] S_E4   = 6'd9;
   localparam logic [5:0] S_E5   = 6'd10;
   localparam logic [5:0] S_E6   = 6'd11;
   localparam logic [5:0] S_E7   = 6'd12;
   localparam logic [5:0] S_E8   = 6'd13;
   localparam logic [5:0] S_E9   = 6'd14;
   localparam logic [5:0] S_E10  = 6'd15;
   localparam logic [5:0] S_E11  = 6'd16;
   localparam logic [5:0] S_E12  = 6'd17;
   localparam logic [5:0] S_E13  = 6'd18;
   localparam logic [5:0] S_E14  = 6'd19;
   localparam logic [5:0] S_E15  = 6'd20;
   localparam logic [5:0] S_DIV  = 6'd21;
   localparam logic [5:0] S_T1   = 6'd22;
   localparam logic [5:0] S_T2   = 6'd23;
   localparam logic [5:0] S_T3   = 6'd24;
   localparam logic [5:0] S_T4   = 6'd25;
   localparam logic [5:0] S_Q1   = 6'd26;
   localparam logic [5:0] S_Q2   = 6'd27;
   localparam logic [5:0] S_Q3   = 6'd28;
   localparam logic [5:0] S_Q4   = 6'd29;
   localparam logic [5:0] S_SQRT = 6'd30;
   localparam logic [5:0] S_NEXT = 6'd31;
   localparam logic [5:0] S_DONE = 6'd32;

   edge_type mem [MAX_EDGES];
   edge_type rd_ff;

   logic [5:0]         state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [4:0]         it_ff, it_in;
   logic signed [30:0] pt_lat_ff, pt_lat_in;
   logic signed [31:0] pt_lon_ff, pt_lon_in;
   wide_type           op_a_ff, op_a_in, op_b_ff, op_b_in;
   logic               neg_ff, neg_in, neg_d_ff;
   logic signed [67:0] prod_ff;
   logic signed [67:0] prod;
   coord_type          px_ff, px_in, py_ff, py_in;
   coord_type          ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   wide_type           abx_ff, abx_in, aby_ff, aby_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [63:0]        acc_ff, acc_in, ab2_ff, ab2_in;
   logic signed [63:0] dot_ff, dot_in, lhs_ff, lhs_in;
   logic               cross_ff, cross_in, inside_ff, inside_in;
   logic [63:0]        rem_ff, rem_in;
   logic [31:0]        q_ff, q_in;
   logic [63:0]        res_ff, res_in, v_ff, v_in, bit_ff, bit_in;
   logic [23:0]        best_ff, best_in;
   logic               out_valid_ff, out_valid_in;
   logic [2:0]         zone_ff, zone_in;
   logic [24:0]        dist_ff, dist_in;

   logic               load_we;
   logic [63:0]        prod64;
   logic [63:0]        rem2;
   logic [63:0]        trial;

   function automatic wide_type lon_mag(input logic signed [31:0] a,
                                        input logic signed [31:0] c);
      logic signed [32:0] d;
      d = {a[31], a} - {c[31], c};
      return d[32] ? -{d[32], d} : {d[32], d};
   endfunction

   function automatic wide_type lat_mag(input logic signed [30:0] a,
                                        input logic signed [30:0] c);
      logic signed [31:0] d;
      d = {a[30], a} - {c[30], c};
      return d[31] ? -{{2{d[31]}}, d} : {{2{d[31]}}, d};
   endfunction

   function automatic logic lon_neg(input logic signed [31:0] a,
                                    input logic signed [31:0] c);
      logic signed [32:0] d;
      d = {a[31], a} - {c[31], c};
      return d[32];
   endfunction

   function automatic logic lat_neg(input logic signed [30:0] a,
                                    input logic signed [30:0] c);
      logic signed [31:0] d;
      d = {a[30], a} - {c[30], c};
      return d[31];
   endfunction

   function automatic wide_type wabs(input wide_type a);
      return a[33] ? -a : a;
   endfunction

   assign prod      = op_a_ff * op_b_ff;
   assign prod64    = prod_ff[63:0];
   assign rem2      = {rem_ff[62:0], 1'b0};
   assign trial     = res_ff + bit_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign load_we   = req_valid && req_ready && !req.req_type &&
                      ({26'd0, req.edge_index} < 32'(MAX_EDGES));
   assign res_valid = out_valid_ff;
   assign res_zone  = zone_ff;
   assign res_dist  = dist_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      count_in     = count_ff;
      it_in        = it_ff;
      pt_lat_in    = pt_lat_ff;
      pt_lon_in    = pt_lon_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      neg_in       = neg_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      abx_in       = abx_ff;
      aby_in       = aby_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      acc_in       = acc_ff;
      ab2_in       = ab2_ff;
      dot_in       = dot_ff;
      lhs_in       = lhs_ff;
      cross_in     = cross_ff;
      inside_in    = inside_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      res_in       = res_ff;
      v_in         = v_ff;
      bit_in       = bit_ff;
      best_in      = best_ff;
      out_valid_in = out_valid_ff && !res_ready;
      zone_in      = zone_ff;
      dist_in      = dist_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!req.req_type) begin
                  if (load_we && req.edge_final) begin
                     count_in = CW'({1'b0, req.edge_index} + 7'd1);
                  end
               end else begin
                  pt_lat_in = req.point_lat;
                  pt_lon_in = req.point_lon;
                  best_in   = DIST_MAX;
                  inside_in = 1'b0;
                  cnt_in    = '0;
                  state_in  = S_P1;
               end
            end
         end
         S_P1: begin
            op_a_in  = lon_mag(pt_lon_ff, cfg.center_lon);
            op_b_in  = {2'b00, cfg.x_scale};
            neg_in   = lon_neg(pt_lon_ff, cfg.center_lon);
            state_in = S_P2;
         end
         S_P2: begin
            op_a_in  = lat_mag(pt_lat_ff, cfg.center_lat);
            op_b_in  = {2'b00, Y_SCALE};
            neg_in   = lat_neg(pt_lat_ff, cfg.center_lat);
            state_in = S_P3;
         end
         S_P3: begin
            px_in    = proj_fin(prod_ff, neg_d_ff);
            state_in = S_P4;
         end
         S_P4: begin
            py_in    = proj_fin(prod_ff, neg_d_ff);
            state_in = (count_ff == '0) ? S_DONE : S_E0;
         end
         S_E0: state_in = S_E1;
         S_E1: begin
            op_a_in  = lon_mag(rd_ff.start_lon, cfg.center_lon);
            op_b_in  = {2'b00, cfg.x_scale};
            neg_in   = lon_neg(rd_ff.start_lon, cfg.center_lon);
            state_in = S_E2;
         end
         S_E2: begin
            op_a_in  = lat_mag(rd_ff.start_lat, cfg.center_lat);
            op_b_in  = {2'b00, Y_SCALE};
            neg_in   = lat_neg(rd_ff.start_lat, cfg.center_lat);
            state_in = S_E3;
         end
         S_E3: begin
            op_a_in  = lon_mag(rd_ff.end_lon, cfg.center_lon);
            op_b_in  = {2'b00, cfg.x_scale};
            neg_in   = lon_neg(rd_ff.end_lon, cfg.center_lon);
            ax_in    = proj_fin(prod_ff, neg_d_ff);
            state_in = S_E4;
         end
         S_E4: begin
            op_a_in  = lat_mag(rd_ff.end_lat, cfg.center_lat);
            op_b_in  = {2'b00, Y_SCALE};
            neg_in   = lat_neg(rd_ff.end_lat, cfg.center_lat);
            ay_in    = proj_fin(prod_ff, neg_d_ff);
            state_in = S_E5;
         end
         S_E5: begin
            bx_in    = proj_fin(prod_ff, neg_d_ff);
            state_in = S_E6;
         end
         S_E6: begin
            by_in    = proj_fin(prod_ff, neg_d_ff);
            state_in = S_E7;
         end
         S_E7: begin
            abx_in   = 34'(bx_ff) - 34'(ax_ff);
            aby_in   = 34'(by_ff) - 34'(ay_ff);
            dx_in    = 34'(px_ff) - 34'(ax_ff);
            dy_in    = 34'(py_ff) - 34'(ay_ff);
            cross_in = (ay_ff > py_ff) != (by_ff > py_ff);
            state_in = S_E8;
         end
         S_E8: begin
            op_a_in  = abx_ff;
            op_b_in  = abx_ff;
            state_in = S_E9;
         end
         S_E9: begin
            op_a_in  = aby_ff;
            op_b_in  = aby_ff;
            state_in = S_E10;
         end
         S_E10: begin
            op_a_in  = dx_ff;
            op_b_in  = abx_ff;
            acc_in   = prod64;
            state_in = S_E11;
         end
         S_E11: begin
            op_a_in  = dy_ff;
            op_b_in  = aby_ff;
            ab2_in   = acc_ff + prod64;
            state_in = S_E12;
         end
         S_E12: begin
            op_a_in  = dx_ff;
            op_b_in  = aby_ff;
            acc_in   = prod64;
            state_in = S_E13;
         end
         S_E13: begin
            op_a_in  = abx_ff;
            op_b_in  = dy_ff;
            dot_in   = $signed(acc_ff + prod64);
            state_in = S_E14;
         end
         S_E14: begin
            lhs_in   = $signed(prod64);
            state_in = S_E15;
         end
         S_E15: begin
            if (cross_ff && ((aby_ff > 0) ? (lhs_ff < $signed(prod64))
                                          : (lhs_ff > $signed(prod64)))) begin
               inside_in = !inside_ff;
            end
            if (ab2_ff != '0 && !dot_ff[63] && dot_ff != '0) begin
               if ($unsigned(dot_ff) >= ab2_ff) begin
                  dx_in    = 34'(px_ff) - 34'(bx_ff);
                  dy_in    = 34'(py_ff) - 34'(by_ff);
                  state_in = S_Q1;
               end else begin
                  rem_in   = $unsigned(dot_ff);
                  q_in     = '0;
                  it_in    = '0;
                  state_in = S_DIV;
               end
            end else begin
               state_in = S_Q1;
            end
         end
         S_DIV: begin
            if (rem2 >= ab2_ff) begin
               rem_in = rem2 - ab2_ff;
               q_in   = {q_ff[30:0], 1'b1};
            end else begin
               rem_in = rem2;
               q_in   = {q_ff[30:0], 1'b0};
            end
            it_in = it_ff + 5'd1;
            if (it_ff == 5'd31) begin
               state_in = S_T1;
            end
         end
         S_T1: begin
            op_a_in  = wabs(abx_ff);
            op_b_in  = {2'b00, q_ff};
            neg_in   = abx_ff[33];
            state_in = S_T2;
         end
         S_T2: begin
            op_a_in  = wabs(aby_ff);
            op_b_in  = {2'b00, q_ff};
            neg_in   = aby_ff[33];
            state_in = S_T3;
         end
         S_T3: begin
            dx_in    = dx_ff - tscale_fin(prod_ff, neg_d_ff);
            state_in = S_T4;
         end
         S_T4: begin
            dy_in    = dy_ff - tscale_fin(prod_ff, neg_d_ff);
            state_in = S_Q1;
         end
         S_Q1: begin
            op_a_in  = wabs(dx_ff);
            op_b_in  = wabs(dx_ff);
            state_in = S_Q2;
         end
         S_Q2: begin
            op_a_in  = wabs(dy_ff);
            op_b_in  = wabs(dy_ff);
            state_in = S_Q3;
         end
         S_Q3: begin
            acc_in   = prod64;
            state_in = S_Q4;
         end
         S_Q4: begin
            v_in     = acc_ff + prod64;
            res_in   = '0;
            bit_in   = 64'h4000_0000_0000_0000;
            it_in    = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            it_in  = it_ff + 5'd1;
            if (it_ff == 5'd31) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (res_ff < {40'd0, best_ff}) begin
               best_in = res_ff[23:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (({1'b0, cnt_ff} + 1'b1) < {1'b0, count_ff}) begin
               state_in = S_E0;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || res_ready) begin
               out_valid_in = 1'b1;
               if (inside_ff) begin
                  priority if (best_ff > cfg.limit[0]) zone_in = ZONE_GREEN;
                  else if (best_ff > cfg.limit[1])     zone_in = ZONE_LIGHT_BLUE;
                  else if (best_ff > cfg.limit[2])     zone_in = ZONE_BLUE;
                  else if (best_ff > cfg.limit[3])     zone_in = ZONE_DARK_BLUE;
                  else if (best_ff > cfg.limit[4])     zone_in = ZONE_YELLOW;
                  else                                 zone_in = ZONE_RED;
                  dist_in = {1'b0, best_ff};
               end else begin
                  zone_in = ZONE_BLACK;
                  dist_in = 25'd0 - {1'b0, best_ff};
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         mem[AW'(req.edge_index)] <= '{start_lat: req.start_lat, start_lon: req.start_lon,
                                       end_lat: req.end_lat, end_lon: req.end_lon};
      end
      rd_ff <= mem[AW'(cnt_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      it_ff     <= it_in;
      pt_lat_ff <= pt_lat_in;
      pt_lon_ff <= pt_lon_in;
      op_a_ff   <= op_a_in;
      op_b_ff   <= op_b_in;
      neg_ff    <= neg_in;
      neg_d_ff  <= neg_ff;
      prod_ff   <= prod;
      px_ff     <= px_in;
      py_ff     <= py_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      bx_ff     <= bx_in;
      by_ff     <= by_in;
      abx_ff    <= abx_in;
      aby_ff    <= aby_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      acc_ff    <= acc_in;
      ab2_ff    <= ab2_in;
      dot_ff    <= dot_in;
      lhs_ff    <= lhs_in;
      cross_ff  <= cross_in;
      inside_ff <= inside_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      res_ff    <= res_in;
      v_ff      <= v_in;
      bit_ff    <= bit_in;
      best_ff   <= best_in;
      zone_ff   <= zone_in;
      dist_ff   <= dist_in;
   end

endmodule
